[sv/pdpc_pkg.sv]
// Shared types, register codes, reset values and widths for the PI drive
// position controller. Every other file of the block depends on this package.
`default_nettype none

package pdpc_pkg;

  localparam int TGT_W    = 16;
  localparam int GAIN_W   = 24;
  localparam int ZONE_W   = 16;
  localparam int LIMIT_W  = 16;
  localparam int SETTLE_W = 16;
  localparam int PERIOD_W = 10;
  localparam int CNT_W    = 21;
  localparam int ERR_W    = 23;
  localparam int SUM_W    = 17;
  localparam int WIDE_W   = 24;
  localparam int TIMER_W  = 16;
  localparam int DRV_W    = 8;
  localparam int IDX_W    = 4;
  localparam int DATA_W   = 24;
  localparam int PKP_W    = GAIN_W + 1 + ERR_W;
  localparam int PKI_W    = GAIN_W + 1 + SUM_W;
  localparam int ACC_W    = PKP_W + 1;
  localparam int FRAC_W   = 16;
  localparam int QUO_W    = ACC_W - FRAC_W;

  localparam logic [IDX_W-1:0] REG_TARGET       = 4'd0;
  localparam logic [IDX_W-1:0] REG_KP_GAIN      = 4'd1;
  localparam logic [IDX_W-1:0] REG_KI_GAIN      = 4'd2;
  localparam logic [IDX_W-1:0] REG_INT_ZONE     = 4'd3;
  localparam logic [IDX_W-1:0] REG_INT_LIMIT    = 4'd4;
  localparam logic [IDX_W-1:0] REG_SETTLE_MS    = 4'd5;
  localparam logic [IDX_W-1:0] REG_SETTLE_ERROR = 4'd6;
  localparam logic [IDX_W-1:0] REG_PERIOD_MS    = 4'd7;

  localparam logic signed [TGT_W-1:0]    RST_TARGET       = 16'sd0;
  localparam logic [GAIN_W-1:0]          RST_KP_GAIN      = 24'd13107;
  localparam logic [GAIN_W-1:0]          RST_KI_GAIN      = 24'd3277;
  localparam logic [ZONE_W-1:0]          RST_INT_ZONE     = 16'd299;
  localparam logic [LIMIT_W-1:0]         RST_INT_LIMIT    = 16'd1000;
  localparam logic [SETTLE_W-1:0]        RST_SETTLE_MS    = 16'd250;
  localparam logic signed [TGT_W-1:0]    RST_SETTLE_ERROR = 16'sd30;
  localparam logic [PERIOD_W-1:0]        RST_PERIOD_MS    = 10'd40;

  localparam logic [SETTLE_W-1:0]        MIN_SETTLE_MS = 16'd250;
  localparam logic [TIMER_W-1:0]         TIMER_MAX     = 16'hFFFF;
  localparam logic signed [QUO_W-1:0]    DRIVE_MAX     = 33'sd127;
  localparam logic signed [ACC_W-1:0]    ROUND_BIAS    = 49'sd65535;

  typedef struct packed {
    logic signed [TGT_W-1:0] target_ticks;
    logic [GAIN_W-1:0]       kp_gain;
    logic [GAIN_W-1:0]       ki_gain;
    logic [ZONE_W-1:0]       integral_zone;
    logic [LIMIT_W-1:0]      integral_limit;
    logic [SETTLE_W-1:0]     settle_ms;
    logic signed [TGT_W-1:0] settle_error;
    logic [PERIOD_W-1:0]     period_ms;
  } cfg_t;

  typedef struct packed {
    logic                    fin;
    logic signed [ERR_W-1:0] err;
    logic signed [SUM_W-1:0] sum;
  } step_t;

endpackage

`default_nettype wire

[sv/pdpc_channels.sv]
// Handshake channels of the PI drive position controller: sample items,
// result items and configuration writes. Depends on pdpc_pkg.
`default_nettype none

interface pdpc_sample_if;
  logic                                        valid;
  logic                                        ready;
  logic                                        start_req;
  logic signed [pdpc_pkg::CNT_W-1:0]           left_count;
  logic signed [pdpc_pkg::CNT_W-1:0]           right_count;

  modport source (output valid, start_req, left_count, right_count, input ready);
  modport sink (input valid, start_req, left_count, right_count, output ready);
endinterface

interface pdpc_result_if;
  logic                                        valid;
  logic                                        ready;
  logic signed [pdpc_pkg::DRV_W-1:0]           drive_power;
  logic                                        move_done;
  logic signed [pdpc_pkg::ERR_W-1:0]           position_error;

  modport source (output valid, drive_power, move_done, position_error, input ready);
  modport sink (input valid, drive_power, move_done, position_error, output ready);
endinterface

interface pdpc_cfg_if;
  logic                                        valid;
  logic                                        ready;
  logic [pdpc_pkg::IDX_W-1:0]                  reg_index;
  logic [pdpc_pkg::DATA_W-1:0]                 wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

[sv/pi_drive_position_controller.sv]
// Top level of the PI drive position controller: configuration registers,
// state update stage and drive stage. Depends on pdpc_pkg and pdpc_channels.
//
//   channel  direction  payload
//   sample   in         start_req, left_count, right_count
//   result   out        drive_power, move_done, position_error
//   cfg      in         reg_index, wr_data (always ready)
//
// One item is accepted per cycle unless the result is stalled.
// The stages are an input register, the state update, the gain products
// and the result register, all advancing together.
// A stalled result holds every stage, so sample.ready is low only then.
// Synchronous reset restores the register defaults and clears the move state.
`default_nettype none

module pi_drive_position_controller (
  input  wire logic     clk,
  input  wire logic     rst,
  pdpc_sample_if.sink   sample,
  pdpc_result_if.source result,
  pdpc_cfg_if.sink      cfg
);
  import pdpc_pkg::*;

  cfg_t  regs;
  step_t step;
  logic  step_valid;
  logic  adv;

  pdpc_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  pdpc_step u_step (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .regs       (regs),
    .sample     (sample),
    .step       (step),
    .step_valid (step_valid)
  );

  pdpc_drive u_drive (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .step       (step),
    .step_valid (step_valid),
    .adv        (adv),
    .result     (result)
  );

endmodule

`default_nettype wire

[sv/pdpc_cfg_regs.sv]
// Configuration register file of the PI drive position controller.
// Depends on pdpc_pkg and pdpc_cfg_if.
`default_nettype none

module pdpc_cfg_regs (
  input  wire logic     clk,
  input  wire logic     rst,
  pdpc_cfg_if.sink      cfg,
  output pdpc_pkg::cfg_t regs
);
  import pdpc_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.target_ticks   <= RST_TARGET;
      regs.kp_gain        <= RST_KP_GAIN;
      regs.ki_gain        <= RST_KI_GAIN;
      regs.integral_zone  <= RST_INT_ZONE;
      regs.integral_limit <= RST_INT_LIMIT;
      regs.settle_ms      <= RST_SETTLE_MS;
      regs.settle_error   <= RST_SETTLE_ERROR;
      regs.period_ms      <= RST_PERIOD_MS;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.reg_index)
        REG_TARGET:       regs.target_ticks   <= $signed(cfg.wr_data[TGT_W-1:0]);
        REG_KP_GAIN:      regs.kp_gain        <= cfg.wr_data[GAIN_W-1:0];
        REG_KI_GAIN:      regs.ki_gain        <= cfg.wr_data[GAIN_W-1:0];
        REG_INT_ZONE:     regs.integral_zone  <= cfg.wr_data[ZONE_W-1:0];
        REG_INT_LIMIT:    regs.integral_limit <= cfg.wr_data[LIMIT_W-1:0];
        REG_SETTLE_MS:    regs.settle_ms      <= cfg.wr_data[SETTLE_W-1:0];
        REG_SETTLE_ERROR: regs.settle_error   <= $signed(cfg.wr_data[TGT_W-1:0]);
        REG_PERIOD_MS:    regs.period_ms      <= cfg.wr_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/pdpc_step.sv]
// Input register, error, integral and settle timer update of the PI drive
// position controller. Depends on pdpc_pkg and pdpc_sample_if.
`default_nettype none

module pdpc_step (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           adv,
  input  wire pdpc_pkg::cfg_t regs,
  pdpc_sample_if.sink         sample,
  output pdpc_pkg::step_t     step,
  output logic                step_valid
);
  import pdpc_pkg::*;

  logic                    s0_valid;
  logic                    s0_start;
  logic signed [CNT_W-1:0] s0_left;
  logic signed [CNT_W-1:0] s0_right;

  logic signed [SUM_W-1:0] integral_sum;
  logic [TIMER_W-1:0]      settle_timer;
  logic                    timer_held;
  logic                    finished;

  logic signed [SUM_W-1:0]  sum0;
  logic [TIMER_W-1:0]       timer0;
  logic                     held0;
  logic                     fin0;
  logic signed [ERR_W-1:0]  err;
  logic [ERR_W-1:0]         mag;
  logic signed [WIDE_W-1:0] sum_try;
  logic signed [WIDE_W-1:0] lim;
  logic signed [WIDE_W-1:0] sum_clamp;
  logic                     in_zone;
  logic [TIMER_W:0]         timer_sum;
  logic [TIMER_W-1:0]       timer_inc;
  logic [SETTLE_W-1:0]      need;
  logic signed [SUM_W-1:0]  integral_sum_next;
  logic [TIMER_W-1:0]       settle_timer_next;
  logic                     timer_held_next;
  logic                     finished_next;

  assign sample.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && sample.valid) begin
      s0_start <= sample.start_req;
      s0_left  <= sample.left_count;
      s0_right <= sample.right_count;
    end
  end

  always_comb begin
    if (s0_start) begin
      sum0   = '0;
      timer0 = '0;
      held0  = 1'b1;
      fin0   = 1'b0;
    end else begin
      sum0   = integral_sum;
      timer0 = settle_timer;
      held0  = timer_held;
      fin0   = finished;
    end

    err = ERR_W'(regs.target_ticks) - ERR_W'(s0_right) + ERR_W'(s0_left);
    mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

    sum_try = WIDE_W'(sum0) + WIDE_W'(err);
    lim     = $signed({{(WIDE_W-LIMIT_W){1'b0}}, regs.integral_limit});
    if (sum_try > lim) begin
      sum_clamp = lim;
    end else if (sum_try < -lim) begin
      sum_clamp = -lim;
    end else begin
      sum_clamp = sum_try;
    end
    in_zone = (err != '0) && (mag < {{(ERR_W-ZONE_W){1'b0}}, regs.integral_zone});

    timer_sum = {1'b0, timer0} + {{(TIMER_W+1-PERIOD_W){1'b0}}, regs.period_ms};
    timer_inc = timer_sum[TIMER_W] ? TIMER_MAX : timer_sum[TIMER_W-1:0];
    need      = (regs.settle_ms < MIN_SETTLE_MS) ? MIN_SETTLE_MS : regs.settle_ms;

    if (fin0) begin
      integral_sum_next = sum0;
      timer_held_next   = held0;
      settle_timer_next = timer0;
      finished_next     = 1'b1;
    end else begin
      integral_sum_next = in_zone ? sum_clamp[SUM_W-1:0] : '0;
      timer_held_next   = held0 && !(err < ERR_W'(regs.settle_error));
      settle_timer_next = timer_held_next ? '0 : timer_inc;
      finished_next     = (settle_timer_next >= need);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
      settle_timer <= '0;
      timer_held   <= 1'b1;
      finished     <= 1'b0;
      step_valid   <= 1'b0;
    end else if (adv) begin
      step_valid <= s0_valid;
      if (s0_valid) begin
        integral_sum <= integral_sum_next;
        settle_timer <= settle_timer_next;
        timer_held   <= timer_held_next;
        finished     <= finished_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      step.fin <= finished_next;
      step.err <= err;
      step.sum <= integral_sum_next;
    end
  end

endmodule

`default_nettype wire

[sv/pdpc_drive.sv]
// Gain products, truncating scale and saturation of the drive command, and
// the result register. Depends on pdpc_pkg and pdpc_result_if.
`default_nettype none

module pdpc_drive (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire pdpc_pkg::cfg_t  regs,
  input  wire pdpc_pkg::step_t step,
  input  wire logic            step_valid,
  output logic                 adv,
  pdpc_result_if.source        result
);
  import pdpc_pkg::*;

  logic                    prod_valid;
  logic                    prod_fin;
  logic signed [ERR_W-1:0] prod_err;
  logic signed [PKP_W-1:0] prod_kp;
  logic signed [PKI_W-1:0] prod_ki;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_biased;
  logic signed [QUO_W-1:0] quo;
  logic signed [DRV_W-1:0] drive;

  assign adv = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_fin <= step.fin;
      prod_err <= step.err;
      prod_kp  <= $signed({1'b0, regs.kp_gain}) * step.err;
      prod_ki  <= $signed({1'b0, regs.ki_gain}) * step.sum;
    end
  end

  always_comb begin
    acc        = ACC_W'(prod_kp) + ACC_W'(prod_ki);
    acc_biased = acc[ACC_W-1] ? (acc + ROUND_BIAS) : acc;
    quo        = QUO_W'(acc_biased >>> FRAC_W);
    if (prod_fin) begin
      drive = '0;
    end else if (quo > DRIVE_MAX) begin
      drive = DRV_W'(DRIVE_MAX);
    end else if (quo < -DRIVE_MAX) begin
      drive = DRV_W'(-DRIVE_MAX);
    end else begin
      drive = quo[DRV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid   <= 1'b0;
      result.valid <= 1'b0;
    end else if (adv) begin
      prod_valid   <= step_valid;
      result.valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.drive_power    <= drive;
      result.move_done      <= prod_fin;
      result.position_error <= prod_err;
    end
  end

endmodule

`default_nettype wire

[test/pi_drive_position_controller_test.sv]
// Self-checking testbench for the PI drive position controller.
// Predicts every command from its own copy of the registers and move state.
// Depends on pdpc_pkg, the pdpc channel interfaces and pi_drive_position_controller.
module pi_drive_position_controller_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pdpc_pkg::*;

  localparam int LATENCY      = 3;
  localparam int SETTLE_WAIT  = 3 * LATENCY;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CNT_MAX      = 2 ** (CNT_W - 1) - 1;
  localparam int CNT_MIN      = -(2 ** (CNT_W - 1));

  typedef struct packed {
    logic signed [DRV_W-1:0] drive_power;
    logic                    move_done;
    logic signed [ERR_W-1:0] position_error;
  } command_t;

  logic clk = 1'b0;
  logic rst;

  pdpc_sample_if smp();
  pdpc_result_if res();
  pdpc_cfg_if    wr();

  pi_drive_position_controller u_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (smp),
    .result (res),
    .cfg    (wr)
  );

  cfg_t                    model_cfg;
  logic signed [SUM_W-1:0] model_sum;
  logic [TIMER_W-1:0]      model_timer;
  logic                    model_held;
  logic                    model_finished;
  command_t                pending_commands[$];

  int mismatch_count = 0;
  int result_count   = 0;
  int cycle_count    = 0;
  int recv_stall     = 0;
  int recv_hold      = 0;
  bit send_idle      = 1'b0;
  bit recv_idle      = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic void reset_model();
    model_cfg.target_ticks   = RST_TARGET;
    model_cfg.kp_gain        = RST_KP_GAIN;
    model_cfg.ki_gain        = RST_KI_GAIN;
    model_cfg.integral_zone  = RST_INT_ZONE;
    model_cfg.integral_limit = RST_INT_LIMIT;
    model_cfg.settle_ms      = RST_SETTLE_MS;
    model_cfg.settle_error   = RST_SETTLE_ERROR;
    model_cfg.period_ms      = RST_PERIOD_MS;
    model_sum      = '0;
    model_timer    = '0;
    model_held     = 1'b1;
    model_finished = 1'b0;
  endfunction

  function automatic command_t compute_command(input logic start,
                                               input logic signed [CNT_W-1:0] left,
                                               input logic signed [CNT_W-1:0] right);
    longint   err, mag, sum, lim, acc, drv, timer, need;
    command_t cmd;
    if (start) begin
      model_sum      = '0;
      model_timer    = '0;
      model_held     = 1'b1;
      model_finished = 1'b0;
    end
    err = longint'($signed(model_cfg.target_ticks)) - longint'(right) + longint'(left);
    drv = 0;
    if (!model_finished) begin
      mag  = (err < 0) ? -err : err;
      lim  = longint'(model_cfg.integral_limit);
      need = (model_cfg.settle_ms < MIN_SETTLE_MS) ? longint'(MIN_SETTLE_MS)
                                                   : longint'(model_cfg.settle_ms);
      if (err != 0 && mag < longint'(model_cfg.integral_zone)) begin
        sum = longint'(model_sum) + err;
        if (sum > lim) sum = lim;
        if (sum < -lim) sum = -lim;
      end else begin
        sum = 0;
      end
      model_sum = sum[SUM_W-1:0];
      acc = longint'(model_cfg.kp_gain) * err + longint'(model_cfg.ki_gain) * sum;
      drv = acc / 65536;
      if (drv > longint'(DRIVE_MAX)) drv = longint'(DRIVE_MAX);
      if (drv < -longint'(DRIVE_MAX)) drv = -longint'(DRIVE_MAX);
      if (err < longint'($signed(model_cfg.settle_error))) model_held = 1'b0;
      if (model_held) begin
        model_timer = '0;
      end else begin
        timer = longint'(model_timer) + longint'(model_cfg.period_ms);
        model_timer = (timer > longint'(TIMER_MAX)) ? TIMER_MAX : timer[TIMER_W-1:0];
      end
      if (longint'(model_timer) >= need) model_finished = 1'b1;
    end
    if (model_finished) drv = 0;
    cmd.drive_power    = drv[DRV_W-1:0];
    cmd.move_done      = model_finished;
    cmd.position_error = err[ERR_W-1:0];
    return cmd;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 100) $display("ERROR: %s", what);
  endtask

  task automatic send_sample(input logic start, input int left, input int right);
    int gap;
    gap = send_idle ? $urandom_range(0, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    smp.valid       <= 1'b1;
    smp.start_req   <= start;
    smp.left_count  <= left[CNT_W-1:0];
    smp.right_count <= right[CNT_W-1:0];
    do @(posedge clk); while (!smp.ready);
    pending_commands.push_back(compute_command(start, left[CNT_W-1:0], right[CNT_W-1:0]));
  endtask

  task automatic wait_for_commands();
    @(negedge clk);
    smp.valid <= 1'b0;
    while (pending_commands.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    wr.valid     <= 1'b1;
    wr.reg_index <= idx;
    wr.wr_data   <= data;
    do @(posedge clk); while (!wr.ready);
    case (idx)
      REG_TARGET:       model_cfg.target_ticks   = data[TGT_W-1:0];
      REG_KP_GAIN:      model_cfg.kp_gain        = data[GAIN_W-1:0];
      REG_KI_GAIN:      model_cfg.ki_gain        = data[GAIN_W-1:0];
      REG_INT_ZONE:     model_cfg.integral_zone  = data[ZONE_W-1:0];
      REG_INT_LIMIT:    model_cfg.integral_limit = data[LIMIT_W-1:0];
      REG_SETTLE_MS:    model_cfg.settle_ms      = data[SETTLE_W-1:0];
      REG_SETTLE_ERROR: model_cfg.settle_error   = data[TGT_W-1:0];
      REG_PERIOD_MS:    model_cfg.period_ms      = data[PERIOD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    wr.valid <= 1'b0;
  endtask

  // Bits above a register's width carry random junk and must be dropped.
  task automatic load_config(input cfg_t c);
    logic [31:0] junk;
    wait_for_commands();
    junk = $urandom();
    write_reg(REG_TARGET, {junk[DATA_W-TGT_W-1:0], c.target_ticks});
    write_reg(REG_KP_GAIN, c.kp_gain);
    write_reg(REG_KI_GAIN, c.ki_gain);
    write_reg(REG_INT_ZONE, {junk[DATA_W-ZONE_W-1:0], c.integral_zone});
    write_reg(REG_INT_LIMIT, {junk[DATA_W-LIMIT_W-1:0], c.integral_limit});
    write_reg(REG_SETTLE_MS, {junk[DATA_W-SETTLE_W-1:0], c.settle_ms});
    write_reg(REG_SETTLE_ERROR, {junk[DATA_W-TGT_W-1:0], c.settle_error});
    write_reg(REG_PERIOD_MS, {junk[DATA_W-PERIOD_W-1:0], c.period_ms});
    write_reg(REG_PERIOD_MS + IDX_W'($urandom_range(1, 8)), junk[DATA_W-1:0]);
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.target_ticks   = TGT_W'($urandom());
    c.kp_gain        = ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom())
                                                   : GAIN_W'($urandom_range(0, 200000));
    c.ki_gain        = ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom())
                                                   : GAIN_W'($urandom_range(0, 50000));
    c.integral_zone  = ($urandom_range(0, 1) == 0) ? ZONE_W'($urandom())
                                                   : ZONE_W'($urandom_range(0, 2000));
    c.integral_limit = ($urandom_range(0, 1) == 0) ? LIMIT_W'($urandom())
                                                   : LIMIT_W'($urandom_range(0, 3000));
    c.settle_ms      = ($urandom_range(0, 3) == 0) ? SETTLE_W'($urandom())
                                                   : SETTLE_W'($urandom_range(250, 800));
    c.settle_error   = ($urandom_range(0, 3) == 0) ? TGT_W'($urandom())
                                                   : TGT_W'($urandom_range(0, 150));
    c.period_ms      = ($urandom_range(0, 3) == 0) ? PERIOD_W'($urandom_range(1, 1000))
                                                   : PERIOD_W'($urandom_range(20, 100));
    return c;
  endfunction

  // One move: the error shrinks step by step unless it is held steady.
  task automatic run_move(input int steps, input int start_err, input bit steady,
                          input bit with_start);
    int err, left, right, target;
    target = int'($signed(model_cfg.target_ticks));
    err = start_err;
    for (int k = 0; k < steps; k++) begin
      left  = rand_between(-262144, 262143);
      right = target + left - err;
      send_sample(with_start && k == 0, left, right);
      if (steady) err = start_err + rand_between(-4, 4);
      else err = err * rand_between(40, 95) / 100 + rand_between(-4, 4);
    end
  endtask

  task automatic test_directed();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    send_sample(1'b1, 0, 0);
    send_sample(1'b0, CNT_MAX, CNT_MIN);
    send_sample(1'b0, CNT_MIN, CNT_MAX);
    send_sample(1'b0, CNT_MIN, CNT_MIN);
    send_sample(1'b0, CNT_MAX, CNT_MAX);
    send_sample(1'b0, 0, 0);
    send_sample(1'b0, 0, 0);
    send_sample(1'b0, 500, -500);
    send_sample(1'b1, 0, -100);
    repeat (11) send_sample(1'b0, 0, -100);
    send_sample(1'b0, 0, -299);
    send_sample(1'b0, 0, -298);
    send_sample(1'b0, 0, 298);
    send_sample(1'b0, 0, 299);
  endtask

  task automatic test_config_extremes();
    cfg_t c;
    c.target_ticks   = {1'b1, {(TGT_W-1){1'b0}}};
    c.kp_gain        = '0;
    c.ki_gain        = '1;
    c.integral_zone  = '1;
    c.integral_limit = '0;
    c.settle_ms      = '0;
    c.settle_error   = {1'b0, {(TGT_W-1){1'b1}}};
    c.period_ms      = '0;
    load_config(c);
    run_move(20, 200, 1'b0, 1'b1);

    c.target_ticks   = {1'b0, {(TGT_W-1){1'b1}}};
    c.kp_gain        = '1;
    c.integral_limit = '1;
    c.settle_ms      = '1;
    c.settle_error   = {1'b1, {(TGT_W-1){1'b0}}};
    c.period_ms      = 10'd1000;
    load_config(c);
    run_move(70, -100000, 1'b1, 1'b1);
    run_move(12, 40, 1'b1, 1'b1);

    c.target_ticks   = '0;
    c.ki_gain        = '0;
    c.integral_zone  = '0;
    c.settle_ms      = MIN_SETTLE_MS;
    c.settle_error   = '0;
    c.period_ms      = 10'd1;
    load_config(c);
    run_move(20, -300, 1'b0, 1'b1);

    c.kp_gain        = 24'd65536;
    c.ki_gain        = 24'd32768;
    c.integral_zone  = 16'd1;
    c.integral_limit = 16'd500;
    c.settle_ms      = 16'd100;
    c.settle_error   = 16'sd5;
    c.period_ms      = 10'd250;
    load_config(c);
    run_move(10, 60, 1'b0, 1'b1);
  endtask

  task automatic test_backpressure();
    load_config(random_cfg());
    send_idle = 1'b0;
    recv_idle = 1'b0;
    recv_hold = 60;
    run_move(40, 1500, 1'b0, 1'b1);
    run_move(15, 2500, 1'b0, 1'b1);
    wait_for_commands();
    run_move(15, 20, 1'b0, 1'b0);
  endtask

  task automatic test_random_moves();
    int sent, moves, kind, steps, err0;
    sent  = 0;
    moves = 0;
    while (sent < RANDOM_ITEMS) begin
      if (moves % 6 == 0) load_config(random_cfg());
      send_idle = $urandom_range(0, 3) != 0;
      recv_idle = $urandom_range(0, 3) != 0;
      kind  = $urandom_range(0, 9);
      steps = rand_between(10, 60);
      err0  = ($urandom_range(0, 4) == 0) ? rand_between(-500000, 500000)
                                          : rand_between(-3000, 3000);
      if (kind < 7) begin
        run_move(steps, err0, kind == 0, 1'b1);
      end else if (kind < 9) begin
        run_move(steps, err0, 1'b0, 1'b0);
      end else begin
        steps = rand_between(3, 20);
        repeat (steps) send_sample($urandom_range(0, 7) == 0, $urandom(), $urandom());
      end
      sent += steps;
      moves++;
    end
  endtask

  always @(negedge clk) begin
    if (recv_hold > 0) begin
      res.ready <= 1'b0;
      recv_hold = recv_hold - 1;
    end else if (recv_stall > 0) begin
      res.ready <= 1'b0;
      recv_stall = recv_stall - 1;
    end else begin
      res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    command_t want;
    if (!rst && res.valid && res.ready) begin
      if (pending_commands.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no item pending", result_count));
      end else begin
        want = pending_commands.pop_front();
        if (res.drive_power !== want.drive_power)
          report_mismatch($sformatf("result %0d drive_power %0d, predicted %0d",
                                    result_count, res.drive_power, want.drive_power));
        if (res.move_done !== want.move_done)
          report_mismatch($sformatf("result %0d move_done %0b, predicted %0b",
                                    result_count, res.move_done, want.move_done));
        if (res.position_error !== want.position_error)
          report_mismatch($sformatf("result %0d position_error %0d, predicted %0d",
                                    result_count, res.position_error, want.position_error));
      end
      result_count++;
      recv_stall = recv_idle ? $urandom_range(0, 8) : 0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    smp.valid       = 1'b0;
    smp.start_req   = 1'b0;
    smp.left_count  = '0;
    smp.right_count = '0;
    res.ready       = 1'b0;
    wr.valid        = 1'b0;
    wr.reg_index    = '0;
    wr.wr_data      = '0;
    rst             = 1'b1;
    reset_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random_moves();
    wait_for_commands();

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
